// File: rtl/dhc_pkg.sv
package dhc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int COMP_W      = 13;
    localparam int FB          = 12;
    localparam int FRAC_W      = 17;
    localparam int DIV_STAGES  = 17;

    localparam logic [COMP_W-1:0] COMP_ONE = 13'd4096;

    localparam logic [2:0] OP_MAP   = 3'd0;
    localparam logic [2:0] OP_HUE   = 3'd1;
    localparam logic [2:0] OP_SAT   = 3'd2;
    localparam logic [2:0] OP_VAL   = 3'd3;
    localparam logic [2:0] OP_ALPHA = 3'd4;

    localparam logic [1:0] MODE_INTERP = 2'd0;
    localparam logic [1:0] MODE_LOW    = 2'd1;
    localparam logic [1:0] MODE_HIGH   = 2'd2;
    localparam logic [1:0] MODE_MID    = 2'd3;

    localparam logic [1:0] CFG_LOW   = 2'd0;
    localparam logic [1:0] CFG_HIGH  = 2'd1;
    localparam logic [1:0] CFG_COUNT = 2'd2;

    typedef struct packed {
        logic       vld;
        logic       is_map;
        logic       status;
        logic [1:0] mode;
    } ctl_t;

    typedef struct packed {
        logic [COMP_W-1:0] h;
        logic [COMP_W-1:0] s;
        logic [COMP_W-1:0] v;
        logic [COMP_W-1:0] a;
    } comp4_t;

    typedef struct packed {
        logic              we;
        logic [2:0]        op;
        logic [IDX_W-1:0]  idx;
        logic [COMP_W-1:0] data;
    } tab_wr_t;

    typedef logic [MAX_ENTRIES-1:0][COMP_W-1:0] comp_tab_t;

    // ramp from two thirds down to zero, rounded to nearest; entry 15 first
    localparam comp_tab_t HUE_INIT = {
        13'd0,    13'd182,  13'd364,  13'd546,
        13'd728,  13'd910,  13'd1092, 13'd1274,
        13'd1457, 13'd1639, 13'd1821, 13'd2003,
        13'd2185, 13'd2367, 13'd2549, 13'd2731
    };

endpackage

// File: rtl/data_to_hsv_colormap_rgba_top.sv
// Every accepted input word gets its own result word, in order.
// Throughput: one map word per cycle without output stalls; 17-stage divider sets depth.
// Table writes and undefined opcodes wait until the pipeline is empty before
// they are taken.
// Reset (aresetn low, synchronous): pipeline emptied, bounds and entry count
// back to defaults, every table entry reads its reset value until written.
module data_to_hsv_colormap_rgba_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // sample[15:0], entry_index[19:16], entry_value[32:20]
    input  logic [2:0]  s_tuser,   // opcode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // red[12:0], green[25:13], blue[38:26], alpha[51:39],
                                   // status[52]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import dhc_pkg::*;

    logic signed [15:0] low_bound_reg;
    logic signed [15:0] high_bound_reg;
    logic [4:0]         entry_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_bound_reg   <= 16'sd0;
            high_bound_reg  <= 16'sd32767;
            entry_count_reg <= 5'd16;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_LOW:   low_bound_reg   <= cfg_data;
                CFG_HIGH:  high_bound_reg  <= cfg_data;
                CFG_COUNT: entry_count_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    logic [4:0]       n_eff;
    logic [IDX_W-1:0] nm1;
    logic [4:0]       nm1_full;

    assign n_eff    = (entry_count_reg < 5'd2) ? 5'd2
                    : (entry_count_reg > 5'(MAX_ENTRIES)) ? 5'(MAX_ENTRIES)
                    : entry_count_reg;
    assign nm1_full = n_eff - 5'd1;
    assign nm1      = nm1_full[IDX_W-1:0];

    // input word
    logic [2:0]         in_op;
    logic signed [15:0] in_sample;
    logic [IDX_W-1:0]   in_idx;
    logic [COMP_W-1:0]  in_val;
    logic               adv;
    logic               busy;
    logic               in_accept;

    assign in_op     = s_tuser;
    assign in_sample = s_tdata[15:0];
    assign in_idx    = s_tdata[19:16];
    assign in_val    = s_tdata[32:20];

    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv && ((in_op == OP_MAP) || !busy);
    assign in_accept = s_tvalid && s_tready;

    logic signed [15:0] lo_s;
    logic signed [15:0] hi_s;
    logic [16:0]        num_full;
    logic [16:0]        den_full;
    logic               wr_bad;
    ctl_t               s0_ctl_next;
    tab_wr_t            tab_wr;

    assign lo_s     = (low_bound_reg > high_bound_reg) ? high_bound_reg : low_bound_reg;
    assign hi_s     = (low_bound_reg > high_bound_reg) ? low_bound_reg : high_bound_reg;
    assign num_full = {in_sample[15], in_sample} - {lo_s[15], lo_s};
    assign den_full = {hi_s[15], hi_s} - {lo_s[15], lo_s};
    assign wr_bad   = ({1'b0, in_idx} >= n_eff) || (in_val > COMP_ONE);

    always_comb begin
        s0_ctl_next.vld    = in_accept;
        s0_ctl_next.is_map = (in_op == OP_MAP);
        if (in_op == OP_MAP) begin
            s0_ctl_next.status = 1'b0;
        end else if (in_op <= OP_ALPHA) begin
            s0_ctl_next.status = wr_bad;
        end else begin
            s0_ctl_next.status = 1'b1;
        end
        priority if (in_sample < lo_s) begin
            s0_ctl_next.mode = MODE_LOW;
        end else if (in_sample > hi_s) begin
            s0_ctl_next.mode = MODE_HIGH;
        end else if (lo_s == hi_s) begin
            s0_ctl_next.mode = MODE_MID;
        end else begin
            s0_ctl_next.mode = MODE_INTERP;
        end
    end

    // tables change only with the pipeline empty
    assign tab_wr.we   = in_accept && (in_op != OP_MAP) && (in_op <= OP_ALPHA) && !wr_bad;
    assign tab_wr.op   = in_op;
    assign tab_wr.idx  = in_idx;
    assign tab_wr.data = in_val;

    ctl_t        s0_ctl_reg;
    logic [15:0] s0_num_reg;
    logic [15:0] s0_den_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_ctl_reg <= '0;
        end else if (adv) begin
            s0_ctl_reg <= s0_ctl_next;
            s0_num_reg <= num_full[15:0];
            s0_den_reg <= den_full[15:0];
        end
    end

    ctl_t              div_ctl;
    logic [FRAC_W-1:0] div_frac;
    logic              div_busy;

    dhc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_ctl   (s0_ctl_reg),
        .in_num   (s0_num_reg),
        .in_den   (s0_den_reg),
        .out_ctl  (div_ctl),
        .out_frac (div_frac),
        .busy     (div_busy)
    );

    // position along the table
    ctl_t        p_ctl_reg;
    logic [20:0] p_pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_ctl_reg <= '0;
        end else if (adv) begin
            p_ctl_reg <= div_ctl;
            p_pos_reg <= div_frac * nm1;
        end
    end

    logic [4:0]        seg_raw;
    logic [IDX_W-1:0]  seg;
    logic [IDX_W-1:0]  seg_m1;
    logic [20:0]       t_full;
    logic [FRAC_W-1:0] t_seg;
    logic [IDX_W-1:0]  addr_a;
    logic [IDX_W-1:0]  addr_b;

    assign seg_raw = p_pos_reg[20:16] + {4'd0, |p_pos_reg[15:0]};
    assign seg     = (seg_raw < 5'd1) ? IDX_W'(1)
                   : (seg_raw > {1'b0, nm1}) ? nm1 : seg_raw[IDX_W-1:0];
    assign seg_m1  = seg - IDX_W'(1);
    assign t_full  = p_pos_reg - {1'b0, seg_m1, 16'h0};
    assign t_seg   = (t_full > 21'h10000) ? 17'h10000 : t_full[FRAC_W-1:0];

    always_comb begin
        unique case (p_ctl_reg.mode)
            MODE_LOW:  begin addr_a = '0;     addr_b = '0;  end
            MODE_HIGH: begin addr_a = nm1;    addr_b = nm1; end
            MODE_MID:  begin addr_a = '0;     addr_b = nm1; end
            default:   begin addr_a = seg_m1; addr_b = seg; end
        endcase
    end

    ctl_t              r_ctl_reg;
    logic [FRAC_W-1:0] r_t_reg;
    comp4_t            rd_a;
    comp4_t            rd_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_ctl_reg <= '0;
        end else if (adv) begin
            r_ctl_reg <= p_ctl_reg;
            r_t_reg   <= (p_ctl_reg.mode == MODE_INTERP) ? t_seg : '0;
        end
    end

    dhc_tables u_tables (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .wr       (tab_wr),
        .addr_a   (addr_a),
        .addr_b   (addr_b),
        .rd_a_reg (rd_a),
        .rd_b_reg (rd_b)
    );

    logic              hsv_busy;
    logic [COMP_W-1:0] out_red;
    logic [COMP_W-1:0] out_green;
    logic [COMP_W-1:0] out_blue;
    logic [COMP_W-1:0] out_alpha;
    logic              out_status;

    dhc_hsv u_hsv (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_ctl     (r_ctl_reg),
        .in_t       (r_t_reg),
        .rd_a       (rd_a),
        .rd_b       (rd_b),
        .out_valid  (m_tvalid),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_alpha  (out_alpha),
        .out_status (out_status),
        .busy       (hsv_busy)
    );

    assign busy    = s0_ctl_reg.vld | div_busy | p_ctl_reg.vld | r_ctl_reg.vld | hsv_busy;
    assign m_tdata = {3'b0, out_status, out_alpha, out_blue, out_green, out_red};

`ifndef SYNTHESIS
    a_write_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        tab_wr.we |-> !busy)
        else $error("table written with words in flight");

    a_non_map_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && (in_op != OP_MAP) && busy |-> !s_tready)
        else $error("non-map word taken while pipeline busy");

    a_comp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_red <= COMP_ONE) && (out_green <= COMP_ONE)
                     && (out_blue <= COMP_ONE) && (out_alpha <= COMP_ONE))
        else $error("component above one");

    a_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_status |-> (out_red == '0) && (out_green == '0)
                                   && (out_blue == '0) && (out_alpha == '0))
        else $error("rejected word carries colour");
`endif

endmodule

// File: rtl/dhc_div.sv
module dhc_div (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   adv,
    input  dhc_pkg::ctl_t          in_ctl,
    input  logic [15:0]            in_num,
    input  logic [15:0]            in_den,
    output dhc_pkg::ctl_t          out_ctl,
    output logic [dhc_pkg::FRAC_W-1:0] out_frac,
    output logic                   busy
);
    import dhc_pkg::*;

    ctl_t              ctl_reg [DIV_STAGES];
    logic [15:0]       r_reg   [DIV_STAGES];
    logic [FRAC_W-1:0] q_reg   [DIV_STAGES];
    logic [15:0]       d_reg   [DIV_STAGES];

    // one quotient bit per stage, restoring
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
        logic [16:0]       r2;
        logic [FRAC_W-1:0] q_in;
        ctl_t              c_in;
        logic [15:0]       d_in;
        logic              qbit;
        logic [16:0]       diff;

        if (j == 0) begin : g_first
            assign r2   = {1'b0, in_num};
            assign q_in = '0;
            assign c_in = in_ctl;
            assign d_in = in_den;
        end else begin : g_rest
            assign r2   = {r_reg[j-1], 1'b0};
            assign q_in = q_reg[j-1];
            assign c_in = ctl_reg[j-1];
            assign d_in = d_reg[j-1];
        end

        assign qbit = (r2 >= {1'b0, d_in});
        assign diff = r2 - {1'b0, d_in};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[j] <= '0;
            end else if (adv) begin
                ctl_reg[j] <= c_in;
                r_reg[j]   <= qbit ? diff[15:0] : r2[15:0];
                q_reg[j]   <= {q_in[FRAC_W-2:0], qbit};
                d_reg[j]   <= d_in;
            end
        end
    end

    always_comb begin
        busy = 1'b0;
        for (int j = 0; j < DIV_STAGES; j++) begin
            busy = busy | ctl_reg[j].vld;
        end
    end

    assign out_ctl  = ctl_reg[DIV_STAGES-1];
    assign out_frac = q_reg[DIV_STAGES-1];

endmodule

// File: rtl/dhc_tables.sv
module dhc_tables (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  dhc_pkg::tab_wr_t            wr,
    input  logic [dhc_pkg::IDX_W-1:0]   addr_a,
    input  logic [dhc_pkg::IDX_W-1:0]   addr_b,
    output dhc_pkg::comp4_t             rd_a_reg,
    output dhc_pkg::comp4_t             rd_b_reg
);
    import dhc_pkg::*;

    logic [COMP_W-1:0] hue_mem   [MAX_ENTRIES];
    logic [COMP_W-1:0] sat_mem   [MAX_ENTRIES];
    logic [COMP_W-1:0] val_mem   [MAX_ENTRIES];
    logic [COMP_W-1:0] alpha_mem [MAX_ENTRIES];

    logic [MAX_ENTRIES-1:0] hue_vld_reg;
    logic [MAX_ENTRIES-1:0] sat_vld_reg;
    logic [MAX_ENTRIES-1:0] val_vld_reg;
    logic [MAX_ENTRIES-1:0] alpha_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            unique case (wr.op)
                OP_HUE:   hue_mem[wr.idx]   <= wr.data;
                OP_SAT:   sat_mem[wr.idx]   <= wr.data;
                OP_VAL:   val_mem[wr.idx]   <= wr.data;
                OP_ALPHA: alpha_mem[wr.idx] <= wr.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hue_vld_reg   <= '0;
            sat_vld_reg   <= '0;
            val_vld_reg   <= '0;
            alpha_vld_reg <= '0;
        end else if (wr.we) begin
            unique case (wr.op)
                OP_HUE:   hue_vld_reg[wr.idx]   <= 1'b1;
                OP_SAT:   sat_vld_reg[wr.idx]   <= 1'b1;
                OP_VAL:   val_vld_reg[wr.idx]   <= 1'b1;
                OP_ALPHA: alpha_vld_reg[wr.idx] <= 1'b1;
                default: ;
            endcase
        end
    end

    // unwritten entries read their reset contents
    always_ff @(posedge aclk) begin
        if (adv) begin
            rd_a_reg.h <= hue_vld_reg[addr_a]   ? hue_mem[addr_a]   : HUE_INIT[addr_a];
            rd_a_reg.s <= sat_vld_reg[addr_a]   ? sat_mem[addr_a]   : COMP_ONE;
            rd_a_reg.v <= val_vld_reg[addr_a]   ? val_mem[addr_a]   : COMP_ONE;
            rd_a_reg.a <= alpha_vld_reg[addr_a] ? alpha_mem[addr_a] : COMP_ONE;
            rd_b_reg.h <= hue_vld_reg[addr_b]   ? hue_mem[addr_b]   : HUE_INIT[addr_b];
            rd_b_reg.s <= sat_vld_reg[addr_b]   ? sat_mem[addr_b]   : COMP_ONE;
            rd_b_reg.v <= val_vld_reg[addr_b]   ? val_mem[addr_b]   : COMP_ONE;
            rd_b_reg.a <= alpha_vld_reg[addr_b] ? alpha_mem[addr_b] : COMP_ONE;
        end
    end

endmodule

// File: rtl/dhc_hsv.sv
module dhc_hsv (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  dhc_pkg::ctl_t                in_ctl,
    input  logic [dhc_pkg::FRAC_W-1:0]   in_t,
    input  dhc_pkg::comp4_t              rd_a,
    input  dhc_pkg::comp4_t              rd_b,
    output logic                         out_valid,
    output logic [dhc_pkg::COMP_W-1:0]   out_red,
    output logic [dhc_pkg::COMP_W-1:0]   out_green,
    output logic [dhc_pkg::COMP_W-1:0]   out_blue,
    output logic [dhc_pkg::COMP_W-1:0]   out_alpha,
    output logic                         out_status,
    output logic                         busy
);
    import dhc_pkg::*;

    function automatic logic [COMP_W-1:0] lerp(
        input logic [COMP_W-1:0] a,
        input logic [COMP_W-1:0] b,
        input logic [FRAC_W-1:0] t,
        input logic              mid
    );
        logic signed [COMP_W:0] d;
        logic signed [31:0]     prod;
        logic [31:0]            acc;
        logic [15:0]            q;
        logic [COMP_W:0]        s2;
        d    = $signed({1'b0, b}) - $signed({1'b0, a});
        prod = d * $signed({1'b0, t});
        acc  = $unsigned(prod) + {3'b0, a, 16'h0} + 32'd32768;
        q    = acc[31:16];
        s2   = {1'b0, a} + {1'b0, b};
        if (mid) begin
            return s2[COMP_W:1];
        end
        return (q > 16'(COMP_ONE)) ? COMP_ONE : q[COMP_W-1:0];
    endfunction

    function automatic logic [COMP_W-1:0] sat14(input logic [COMP_W:0] x);
        return (x > {1'b0, COMP_ONE}) ? COMP_ONE : x[COMP_W-1:0];
    endfunction

    // interpolated components
    ctl_t   i_ctl_reg;
    comp4_t i_comp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_ctl_reg <= '0;
        end else if (adv) begin
            i_ctl_reg    <= in_ctl;
            i_comp_reg.h <= lerp(rd_a.h, rd_b.h, in_t, in_ctl.mode == MODE_MID);
            i_comp_reg.s <= lerp(rd_a.s, rd_b.s, in_t, in_ctl.mode == MODE_MID);
            i_comp_reg.v <= lerp(rd_a.v, rd_b.v, in_t, in_ctl.mode == MODE_MID);
            i_comp_reg.a <= lerp(rd_a.a, rd_b.a, in_t, in_ctl.mode == MODE_MID);
        end
    end

    // sector and fraction of hue
    logic [14:0]       h6;
    ctl_t              h1_ctl_reg;
    logic [2:0]        h1_sec_reg;
    logic [FB-1:0]     h1_f_reg;
    logic [COMP_W-1:0] h1_s_reg;
    logic [COMP_W-1:0] h1_v_reg;
    logic [COMP_W-1:0] h1_a_reg;
    logic [14:0]       h6_next;

    assign h6      = 15'({i_comp_reg.h, 2'b0}) + 15'({i_comp_reg.h, 1'b0});
    assign h6_next = (h6 >= 15'd24576) ? 15'd0 : h6;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h1_ctl_reg <= '0;
        end else if (adv) begin
            h1_ctl_reg <= i_ctl_reg;
            h1_sec_reg <= h6_next[14:12];
            h1_f_reg   <= h6_next[FB-1:0];
            h1_s_reg   <= i_comp_reg.s;
            h1_v_reg   <= i_comp_reg.v;
            h1_a_reg   <= i_comp_reg.a;
        end
    end

    // saturation products
    ctl_t              h2_ctl_reg;
    logic [2:0]        h2_sec_reg;
    logic [COMP_W-1:0] h2_oms_reg;
    logic [24:0]       h2_sf_reg;
    logic [24:0]       h2_sof_reg;
    logic [COMP_W-1:0] h2_s_reg;
    logic [COMP_W-1:0] h2_v_reg;
    logic [COMP_W-1:0] h2_a_reg;
    logic [COMP_W-1:0] omf;
    logic [25:0]       sof_full;

    assign omf      = COMP_ONE - {1'b0, h1_f_reg};
    assign sof_full = h1_s_reg * omf;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h2_ctl_reg <= '0;
        end else if (adv) begin
            h2_ctl_reg <= h1_ctl_reg;
            h2_sec_reg <= h1_sec_reg;
            h2_oms_reg <= COMP_ONE - h1_s_reg;
            h2_sf_reg  <= h1_s_reg * h1_f_reg;
            h2_sof_reg <= sof_full[24:0];
            h2_s_reg   <= h1_s_reg;
            h2_v_reg   <= h1_v_reg;
            h2_a_reg   <= h1_a_reg;
        end
    end

    // products with value
    ctl_t              h3_ctl_reg;
    logic [2:0]        h3_sec_reg;
    logic [25:0]       h3_p_reg;
    logic [37:0]       h3_q_reg;
    logic [37:0]       h3_t_reg;
    logic              h3_s_zero_reg;
    logic [COMP_W-1:0] h3_v_reg;
    logic [COMP_W-1:0] h3_a_reg;
    logic [24:0]       qf;
    logic [24:0]       tf;

    assign qf = 25'h1000000 - h2_sf_reg;
    assign tf = 25'h1000000 - h2_sof_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h3_ctl_reg <= '0;
        end else if (adv) begin
            h3_ctl_reg    <= h2_ctl_reg;
            h3_sec_reg    <= h2_sec_reg;
            h3_p_reg      <= h2_v_reg * h2_oms_reg;
            h3_q_reg      <= h2_v_reg * qf;
            h3_t_reg      <= h2_v_reg * tf;
            h3_s_zero_reg <= (h2_s_reg == '0);
            h3_v_reg      <= h2_v_reg;
            h3_a_reg      <= h2_a_reg;
        end
    end

    // round, saturate and pick by sector
    logic [26:0]       p_rnd;
    logic [38:0]       q_rnd;
    logic [38:0]       t_rnd;
    logic [COMP_W-1:0] pv;
    logic [COMP_W-1:0] qv;
    logic [COMP_W-1:0] tv;
    logic [COMP_W-1:0] r_next;
    logic [COMP_W-1:0] g_next;
    logic [COMP_W-1:0] b_next;

    assign p_rnd = {1'b0, h3_p_reg} + 27'd2048;
    assign q_rnd = {1'b0, h3_q_reg} + 39'h800000;
    assign t_rnd = {1'b0, h3_t_reg} + 39'h800000;
    assign pv    = sat14(p_rnd[FB+COMP_W:FB]);
    assign qv    = sat14(q_rnd[2*FB+COMP_W:2*FB]);
    assign tv    = sat14(t_rnd[2*FB+COMP_W:2*FB]);

    always_comb begin
        r_next = h3_v_reg;
        g_next = pv;
        b_next = qv;
        priority if (h3_v_reg == '0) begin
            r_next = '0;
            g_next = '0;
            b_next = '0;
        end else if (h3_s_zero_reg) begin
            r_next = h3_v_reg;
            g_next = h3_v_reg;
            b_next = h3_v_reg;
        end else begin
            unique case (h3_sec_reg)
                3'd0: begin r_next = h3_v_reg; g_next = tv; b_next = pv; end
                3'd1: begin r_next = qv; g_next = h3_v_reg; b_next = pv; end
                3'd2: begin r_next = pv; g_next = h3_v_reg; b_next = tv; end
                3'd3: begin r_next = pv; g_next = qv; b_next = h3_v_reg; end
                3'd4: begin r_next = tv; g_next = pv; b_next = h3_v_reg; end
                default: begin r_next = h3_v_reg; g_next = pv; b_next = qv; end
            endcase
        end
    end

    ctl_t              o_ctl_reg;
    logic [COMP_W-1:0] o_red_reg;
    logic [COMP_W-1:0] o_green_reg;
    logic [COMP_W-1:0] o_blue_reg;
    logic [COMP_W-1:0] o_alpha_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_ctl_reg <= '0;
        end else if (adv) begin
            o_ctl_reg   <= h3_ctl_reg;
            o_red_reg   <= h3_ctl_reg.is_map ? r_next : '0;
            o_green_reg <= h3_ctl_reg.is_map ? g_next : '0;
            o_blue_reg  <= h3_ctl_reg.is_map ? b_next : '0;
            o_alpha_reg <= h3_ctl_reg.is_map ? h3_a_reg : '0;
        end
    end

    assign out_valid  = o_ctl_reg.vld;
    assign out_status = o_ctl_reg.status;
    assign out_red    = o_red_reg;
    assign out_green  = o_green_reg;
    assign out_blue   = o_blue_reg;
    assign out_alpha  = o_alpha_reg;
    assign busy       = i_ctl_reg.vld | h1_ctl_reg.vld | h2_ctl_reg.vld
                      | h3_ctl_reg.vld | o_ctl_reg.vld;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import dhc_pkg::*;

    typedef struct {
        logic [12:0] red;
        logic [12:0] green;
        logic [12:0] blue;
        logic [12:0] alpha;
        logic        status;
    } rgba_t;

    class colour_board;
        logic [12:0] hue_t[16], sat_t[16], val_t[16], alp_t[16];
        logic signed [15:0] lo_b, hi_b;
        logic [4:0]  n_cfg;
        rgba_t       pending[$];
        int          errors;
        int          maps;
        int          writes;

        function void clear();
            int i;
            lo_b = 0; hi_b = 16'sd32767; n_cfg = 16;
            for (i = 0; i < 16; i++) begin
                hue_t[i] = 13'((2731 * (15 - i) * 2 + 15) / 30);
                sat_t[i] = 13'd4096; val_t[i] = 13'd4096; alp_t[i] = 13'd4096;
            end
            errors = 0; maps = 0; writes = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] d);
            if (idx == CFG_LOW) lo_b = d;
            else if (idx == CFG_HIGH) hi_b = d;
            else if (idx == CFG_COUNT) n_cfg = d[4:0];
        endfunction

        function longint sat1(longint x);
            return x > 4096 ? 4096 : x;
        endfunction

        function void note_input(logic [2:0] op, logic signed [15:0] smp,
                                 logic [3:0] idx, logic [12:0] val);
            rgba_t   r;
            int      n, k, lo, hi, sct;
            longint  c[4], a, b, num, den, frac, pos, seg, tt;
            longint  h, s, v, h6, f, p, q, t2, o2;
            n = n_cfg < 2 ? 2 : (n_cfg > 16 ? 16 : n_cfg);
            r = '{0, 0, 0, 0, 0};
            if (op == OP_MAP) begin
                maps++;
                lo = lo_b; hi = hi_b;
                if (lo > hi) begin k = lo; lo = hi; hi = k; end
                if (smp < lo) begin
                    c = '{hue_t[0], sat_t[0], val_t[0], alp_t[0]};
                end else if (smp > hi) begin
                    c = '{hue_t[n-1], sat_t[n-1], val_t[n-1], alp_t[n-1]};
                end else if (lo == hi) begin
                    c[0] = (hue_t[0] + hue_t[n-1]) >> 1;
                    c[1] = (sat_t[0] + sat_t[n-1]) >> 1;
                    c[2] = (val_t[0] + val_t[n-1]) >> 1;
                    c[3] = (alp_t[0] + alp_t[n-1]) >> 1;
                end else begin
                    num = smp - lo; den = hi - lo;
                    frac = (num << 16) / den;
                    pos = frac * (n - 1);
                    seg = (pos + 65535) >> 16;
                    if (seg < 1) seg = 1;
                    if (seg > n - 1) seg = n - 1;
                    tt = pos - (seg - 1) * 65536;
                    if (tt > 65536) tt = 65536;
                    for (k = 0; k < 4; k++) begin
                        case (k)
                            0: begin a = hue_t[seg-1]; b = hue_t[seg]; end
                            1: begin a = sat_t[seg-1]; b = sat_t[seg]; end
                            2: begin a = val_t[seg-1]; b = val_t[seg]; end
                            default: begin a = alp_t[seg-1]; b = alp_t[seg]; end
                        endcase
                        c[k] = sat1((a * (65536 - tt) + b * tt + 32768) >> 16);
                    end
                end
                h = c[0]; s = c[1]; v = c[2];
                if (v == 0) begin
                    r.red = 0; r.green = 0; r.blue = 0;
                end else if (s == 0) begin
                    r.red = 13'(v); r.green = 13'(v); r.blue = 13'(v);
                end else begin
                    h6 = h * 6;
                    if (h6 >= 6 * 4096) h6 = 0;
                    sct = int'(h6 >> 12); f = h6 & 4095; o2 = 4096 * 4096;
                    p = sat1((v * (4096 - s) + 2048) >> 12);
                    q = sat1((v * (o2 - s * f) + o2 / 2) >> 24);
                    t2 = sat1((v * (o2 - s * (4096 - f)) + o2 / 2) >> 24);
                    case (sct)
                        0: begin r.red = 13'(v); r.green = 13'(t2); r.blue = 13'(p); end
                        1: begin r.red = 13'(q); r.green = 13'(v); r.blue = 13'(p); end
                        2: begin r.red = 13'(p); r.green = 13'(v); r.blue = 13'(t2); end
                        3: begin r.red = 13'(p); r.green = 13'(q); r.blue = 13'(v); end
                        4: begin r.red = 13'(t2); r.green = 13'(p); r.blue = 13'(v); end
                        default: begin r.red = 13'(v); r.green = 13'(p); r.blue = 13'(q); end
                    endcase
                end
                r.alpha = 13'(c[3]);
            end else if (op <= OP_ALPHA) begin
                writes++;
                if (idx >= n || val > 4096) r.status = 1'b1;
                else if (op == OP_HUE) hue_t[idx] = val;
                else if (op == OP_SAT) sat_t[idx] = val;
                else if (op == OP_VAL) val_t[idx] = val;
                else alp_t[idx] = val;
            end else begin
                r.status = 1'b1;
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [55:0] d);
            rgba_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word %h", $time, d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[12:0] !== e.red || d[25:13] !== e.green || d[38:26] !== e.blue ||
                d[51:39] !== e.alpha || d[52] !== e.status) begin
                $display("%0t: mismatch exp r%0d g%0d b%0d a%0d s%0d got r%0d g%0d b%0d a%0d s%0d",
                         $time, e.red, e.green, e.blue, e.alpha, e.status,
                         d[12:0], d[25:13], d[38:26], d[51:39], d[52]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0, s_tready;
    logic [39:0] s_tdata = 0;
    logic [2:0]  s_tuser = 0;
    logic        m_tvalid, m_tready = 0;
    logic [55:0] m_tdata;
    logic        cfg_valid = 0, cfg_ready;
    logic [1:0]  cfg_index = 0;
    logic [15:0] cfg_data = 0;

    colour_board board = new();
    int          hold_off = 0;
    bit          hold_req = 0;
    bit          hold_used = 0;
    bit          sending_done = 0;

    always #10 aclk = ~aclk;

    data_to_hsv_colormap_rgba_top u_top (.*);

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // hold valid across back-to-back words; drop it only for a gap
    task automatic send_word(logic [2:0] op, logic [15:0] smp, logic [3:0] idx,
                             logic [12:0] val);
        int g;
        g = (hold_off > 0) ? 0 : gap_len();
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, val, idx, smp};
        do @(posedge aclk); while (!s_tready);
        board.note_input(op, smp, idx, val);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] d);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
        do @(posedge aclk); while (!cfg_ready);
        board.set_reg(idx, d);
        @(negedge aclk);
        cfg_valid <= 0;
        @(negedge aclk);
    endtask

    task automatic send_random();
        int r;
        logic [3:0] idx;
        r = $urandom_range(0, 99);
        idx = 4'($urandom_range(0, 15));
        if (r < 70)
            send_word(OP_MAP, 16'($urandom), idx, 13'($urandom));
        else if (r < 92)
            send_word(3'($urandom_range(1, 4)), 16'($urandom), idx,
                      ($urandom_range(0, 9) == 0) ? 13'($urandom) :
                      13'($urandom_range(0, 4096)));
        else
            send_word(3'($urandom_range(5, 7)), 16'($urandom), idx, 13'($urandom));
    endtask

    // receiver: random stalls, plus one long hold-off when requested
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            m_tready <= 0;
            hold_off <= hold_off - 1;
        end else if (hold_req && !hold_used) begin
            m_tready  <= 0;
            hold_off  <= 200;
            hold_used <= 1;
        end else begin
            m_tready <= ($urandom_range(0, 9) < 7) ? 1'b1 : ($urandom_range(0, 30) == 0);
        end
    end

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);

    initial begin
        logic signed [15:0] lo, hi;
        int ph, i;
        board.clear();
        repeat (10) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        // directed: extremes, each defined opcode, undefined opcodes 5 and 7, bound cases
        send_word(OP_MAP, 16'h8000, 0, 0);
        send_word(OP_MAP, 16'h7FFF, 0, 0);
        send_word(OP_MAP, 0, 0, 0);
        send_word(OP_MAP, 16'd16383, 0, 0);
        send_word(OP_HUE, 0, 4'd15, 13'd4096);
        send_word(OP_SAT, 0, 4'd3, 13'd0);
        send_word(OP_VAL, 0, 4'd5, 13'd0);
        send_word(OP_ALPHA, 0, 4'd0, 13'd4097);
        send_word(OP_ALPHA, 0, 4'd1, 13'h1FFF);
        send_word(OP_MAP, 16'd32767 / 15 * 3, 0, 0);
        send_word(OP_MAP, 16'd32767 / 15 * 5, 0, 0);
        send_word(OP_MAP, 16'h7FFF, 0, 0);
        send_word(3'd5, 16'hFFFF, 4'hF, 13'h1FFF);
        send_word(3'd7, 0, 0, 0);
        drain();
        write_reg(CFG_LOW, 16'sd100);
        write_reg(CFG_HIGH, 16'sd100);
        write_reg(CFG_COUNT, 16'd2);
        send_word(OP_MAP, 16'sd100, 0, 0);
        send_word(OP_MAP, 16'sd99, 0, 0);
        send_word(OP_MAP, 16'sd101, 0, 0);
        send_word(OP_HUE, 0, 4'd2, 13'd10);
        drain();
        write_reg(CFG_LOW, 16'sd500);
        write_reg(CFG_HIGH, -16'sd500);
        write_reg(CFG_COUNT, 16'd31);
        send_word(OP_MAP, 16'sd0, 0, 0);
        send_word(OP_MAP, -16'sd500, 0, 0);
        drain();
        // random phases with varied settings
        for (ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin lo = 16'h8000; hi = 16'h7FFF; end
                1: begin lo = 16'($urandom); hi = 16'($urandom); end
                2: begin
                    lo = 16'($urandom_range(0, 200));
                    hi = 16'(lo + 16'($urandom_range(0, 3)));
                end
                default: begin lo = 16'($urandom); hi = lo; end
            endcase
            write_reg(CFG_LOW, lo);
            write_reg(CFG_HIGH, hi);
            write_reg(CFG_COUNT, (ph == 5) ? 16'd0 : 16'($urandom_range(1, 31)));
            for (i = 0; i < 150; i++) begin
                if (ph == 3 && i == 20) hold_req <= 1;
                send_random();
            end
            drain();
        end
        sending_done = 1;
    end

    initial begin
        wait (sending_done);
        $display("tb_top: %0d map words, %0d table writes checked over 15 settings",
                 board.maps, board.writes);
        $display("tb_top: bounds reversed, equal, full range; counts below 2 and above 16");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_top: done, errors");
        $finish;
    end
endmodule
